FILE: src/ww_pkg.sv
// ============================================================================
// ww_pkg: shared types and constants for the Wireworld generation stream
// Cell codes, item structs, register indexes and default sizes.
// ============================================================================
`default_nettype none

package ww_pkg;

    // Default grid limits
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Configuration registers
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;
    localparam logic [CFG_DATA_W-1:0] GRID_COLS_RESET = 7'd40;
    localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RESET = 7'd40;
    localparam int COLS_MIN = 2;
    localparam int ROWS_MIN = 1;

    // Input item kinds
    localparam logic FUNC_CELL  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam int STATE_W = 2;
    localparam int IDX_W   = 6;

    typedef enum logic [STATE_W-1:0] {
        CELL_EMPTY  = 2'd0,
        CELL_HEAD   = 2'd1,
        CELL_TAIL   = 2'd2,
        CELL_COPPER = 2'd3
    } cell_t;

    typedef struct packed {
        logic               func;
        logic [STATE_W-1:0] cell_state;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic [IDX_W-1:0]   cell_row;
        logic [IDX_W-1:0]   cell_col;
        logic               frame_end;
    } out_item_t;

    // Position info of one item, from the raster counters to the window stage
    typedef struct packed {
        logic             emit;
        logic             last;
        logic             up;
        logic             down;
        logic             left;
        logic             right;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } pos_t;

endpackage

`default_nettype wire

FILE: src/ww_ram.sv
// ============================================================================
// ww_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ============================================================================
`default_nettype none

module ww_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/ww_pos_ctrl.sv
// ============================================================================
// ww_pos_ctrl: raster position counters
// Tracks the row/column of the incoming item and derives the emitted cell.
// ============================================================================
`default_nettype none

module ww_pos_ctrl #(
    parameter int MAX_COLS = ww_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ww_pkg::DEF_MAX_ROWS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [ww_pkg::CFG_DATA_W-1:0]     cfg_cols,
    input  wire logic [ww_pkg::CFG_DATA_W-1:0]     cfg_rows,
    input  wire logic                              accept,
    output ww_pkg::pos_t                           pos,
    output logic      [$clog2(MAX_COLS)-1:0]       col_addr
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 3);
    localparam int AW = $clog2(MAX_COLS);

    logic [CW-1:0] cols;
    logic [RW-1:0] rows;
    logic [CW-1:0] cnt_c_reg;
    logic [RW-1:0] cnt_r_reg;
    logic [CW-1:0] cur_c;
    logic [RW-1:0] cur_r;
    logic [CW-1:0] inc_c;
    logic [CW-1:0] nxt_c;
    logic [RW-1:0] nxt_r;
    logic [CW-1:0] c;
    logic [RW-1:0] r;
    logic          emit;
    logic          last;

    // clamp sizes into the supported range
    always_comb begin
        priority if (cfg_cols < ww_pkg::CFG_DATA_W'(ww_pkg::COLS_MIN)) begin
            cols = CW'(ww_pkg::COLS_MIN);
        end else if (32'(cfg_cols) > 32'(MAX_COLS)) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(cfg_cols);
        end
        priority if (cfg_rows < ww_pkg::CFG_DATA_W'(ww_pkg::ROWS_MIN)) begin
            rows = RW'(ww_pkg::ROWS_MIN);
        end else if (32'(cfg_rows) > 32'(MAX_ROWS)) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(cfg_rows);
        end
    end

    always_comb begin
        // a stale column count (width shrank) wraps first
        if (cnt_c_reg >= cols) begin
            cur_c = '0;
            cur_r = cnt_r_reg + RW'(1);
        end else begin
            cur_c = cnt_c_reg;
            cur_r = cnt_r_reg;
        end
        inc_c = cur_c + CW'(1);
        if (inc_c >= cols) begin
            nxt_c = '0;
            nxt_r = cur_r + RW'(1);
        end else begin
            nxt_c = inc_c;
            nxt_r = cur_r;
        end

        emit = (cur_r >= RW'(2)) || ((cur_r == RW'(1)) && (cur_c != '0));
        if (cur_c != '0) begin
            r = cur_r - RW'(1);
            c = cur_c - CW'(1);
        end else begin
            r = cur_r - RW'(2);
            c = cols - CW'(1);
        end
        last = emit && ((r + RW'(1)) >= rows) && ((c + CW'(1)) == cols);

        pos.emit  = emit;
        pos.last  = last;
        pos.up    = (r != '0);
        pos.down  = (r + RW'(1)) < rows;
        pos.left  = (c != '0);
        pos.right = (c + CW'(1)) < cols;
        pos.row   = ww_pkg::IDX_W'(r);
        pos.col   = ww_pkg::IDX_W'(c);
    end

    assign col_addr = cur_c[AW-1:0];

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            cnt_c_reg <= '0;
            cnt_r_reg <= '0;
        end else if (accept) begin
            if (last) begin
                cnt_c_reg <= '0;
                cnt_r_reg <= '0;
            end else begin
                cnt_c_reg <= nxt_c;
                cnt_r_reg <= nxt_r;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/ww_window.sv
// ============================================================================
// ww_window: 3x3 window, Wireworld rule and output register
// Takes the line-buffer read, shifts the window, writes the buffers back.
// ============================================================================
`default_nettype none

module ww_window #(
    parameter int MAX_COLS = ww_pkg::DEF_MAX_COLS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire ww_pkg::pos_t                        pos,
    input  wire logic [$clog2(MAX_COLS)-1:0]         col_addr,
    input  wire logic [ww_pkg::STATE_W-1:0]          cell_in,
    input  wire logic [2*ww_pkg::STATE_W-1:0]        rd_data,
    input  wire logic                                m_ready,
    output logic                                     take_ok,
    output logic                                     wr_en,
    output logic      [$clog2(MAX_COLS)-1:0]         wr_addr,
    output logic      [2*ww_pkg::STATE_W-1:0]        wr_data,
    output logic                                     m_valid,
    output ww_pkg::out_item_t                        m_item
);

    localparam int AW  = $clog2(MAX_COLS);
    localparam int SW  = ww_pkg::STATE_W;
    localparam int TOP = 0;
    localparam int MID = 1;
    localparam int BOT = 2;

    logic                b_vld_reg;
    ww_pkg::pos_t        b_pos_reg;
    logic [AW-1:0]       b_addr_reg;
    logic [SW-1:0]       b_v_reg;
    logic [SW-1:0]       col_a_reg [3];   // oldest column
    logic [SW-1:0]       col_b_reg [3];   // middle column, holds the center
    logic                o_vld_reg;
    ww_pkg::out_item_t   o_item_reg;

    logic [SW-1:0] above;
    logic [SW-1:0] mid;
    logic          b_adv;
    logic [3:0]    heads;
    logic [SW-1:0] next_state;

    assign above = rd_data[SW-1:0];
    assign mid   = rd_data[2*SW-1:SW];

    assign b_adv   = b_vld_reg && (!b_pos_reg.emit || !o_vld_reg || m_ready);
    assign take_ok = !b_vld_reg || b_adv;

    // buffer shift: above <= middle, middle <= new cell
    assign wr_en   = b_adv;
    assign wr_addr = b_addr_reg;
    assign wr_data = {b_v_reg, mid};

    always_comb begin
        heads = 4'(b_pos_reg.up && b_pos_reg.left && (col_a_reg[TOP] == ww_pkg::CELL_HEAD))
              + 4'(b_pos_reg.up && (col_b_reg[TOP] == ww_pkg::CELL_HEAD))
              + 4'(b_pos_reg.up && b_pos_reg.right && (above == ww_pkg::CELL_HEAD))
              + 4'(b_pos_reg.left && (col_a_reg[MID] == ww_pkg::CELL_HEAD))
              + 4'(b_pos_reg.right && (mid == ww_pkg::CELL_HEAD))
              + 4'(b_pos_reg.down && b_pos_reg.left && (col_a_reg[BOT] == ww_pkg::CELL_HEAD))
              + 4'(b_pos_reg.down && (col_b_reg[BOT] == ww_pkg::CELL_HEAD))
              + 4'(b_pos_reg.down && b_pos_reg.right && (b_v_reg == ww_pkg::CELL_HEAD));
    end

    always_comb begin
        unique case (ww_pkg::cell_t'(col_b_reg[MID]))
            ww_pkg::CELL_EMPTY: begin
                next_state = ww_pkg::CELL_EMPTY;
            end
            ww_pkg::CELL_HEAD: begin
                next_state = ww_pkg::CELL_TAIL;
            end
            ww_pkg::CELL_TAIL: begin
                next_state = ww_pkg::CELL_COPPER;
            end
            ww_pkg::CELL_COPPER: begin
                next_state = ((heads == 4'd1) || (heads == 4'd2)) ? ww_pkg::CELL_HEAD
                                                                  : ww_pkg::CELL_COPPER;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                col_a_reg[i] <= ww_pkg::CELL_EMPTY;
                col_b_reg[i] <= ww_pkg::CELL_EMPTY;
            end
        end else begin
            if (accept) begin
                b_vld_reg <= 1'b1;
            end else if (b_adv) begin
                b_vld_reg <= 1'b0;
            end

            if (b_adv) begin
                for (int i = 0; i < 3; i++) begin
                    col_a_reg[i] <= col_b_reg[i];
                end
                col_b_reg[TOP] <= above;
                col_b_reg[MID] <= mid;
                col_b_reg[BOT] <= b_v_reg;
            end

            if (b_adv && b_pos_reg.emit) begin
                o_vld_reg <= 1'b1;
            end else if (m_ready) begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        if (accept) begin
            b_pos_reg  <= pos;
            b_addr_reg <= col_addr;
            b_v_reg    <= cell_in;
        end
        if (b_adv && b_pos_reg.emit) begin
            o_item_reg.next_state <= next_state;
            o_item_reg.cell_row   <= b_pos_reg.row;
            o_item_reg.cell_col   <= b_pos_reg.col;
            o_item_reg.frame_end  <= b_pos_reg.last;
        end
    end

    assign m_valid = o_vld_reg;
    assign m_item  = o_item_reg;

endmodule

`default_nettype wire

FILE: src/wireworld_generation_stream_top.sv
// ============================================================================
// wireworld_generation_stream_top: Wireworld next-generation stream
// Raster cells in, next-generation cells out one row and one cell behind.
// ============================================================================
//
//  channel | ports                          | moves
//  --------+--------------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_item       | one cell or flush item per handshake
//  result  | m_valid, m_ready, m_item       | one next-generation cell with row/col
//  config  | cfg_wr_en, cfg_wr_index, _data | register write, no wait, no read-back
//
//  One item per cycle sustained while results are taken. An item's handshake
//  loads the line-buffer read and the window stage; its window/rule result is
//  then loaded into the output register, from which it is taken.
//  After reset a clearing pass writes every line-buffer entry to empty, one per
//  cycle: s_ready stays low until the pass ends. Config writes are taken then.
//  A stalled result holds the window stage; input is still taken while the
//  window stage is empty or its item makes no result.
//
`default_nettype none

module wireworld_generation_stream_top #(
    parameter int MAX_COLS = ww_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ww_pkg::DEF_MAX_ROWS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input items
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ww_pkg::in_item_t                  s_item,
    // result items
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ww_pkg::out_item_t                      m_item,
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [ww_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [ww_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int AW = $clog2(MAX_COLS);
    localparam int SW = ww_pkg::STATE_W;

    logic [ww_pkg::CFG_DATA_W-1:0] cfg_cols_reg;
    logic [ww_pkg::CFG_DATA_W-1:0] cfg_rows_reg;

    // clearing pass over the line buffers
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          accept;
    logic          take_ok;
    ww_pkg::pos_t  pos;
    logic [AW-1:0] col_addr;
    logic [SW-1:0] cell_in;

    // line buffers share one RAM: [2*SW-1:SW] middle row, [SW-1:0] row above
    logic            win_wr_en;
    logic [AW-1:0]   win_wr_addr;
    logic [2*SW-1:0] win_wr_data;
    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    logic [2*SW-1:0] ram_wr_data;
    logic [2*SW-1:0] ram_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols_reg <= ww_pkg::GRID_COLS_RESET;
            cfg_rows_reg <= ww_pkg::GRID_ROWS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                ww_pkg::REG_GRID_COLS: begin
                    cfg_cols_reg <= cfg_wr_data;
                end
                ww_pkg::REG_GRID_ROWS: begin
                    cfg_rows_reg <= cfg_wr_data;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MAX_COLS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign s_ready = !clr_busy_reg && take_ok;
    assign accept  = s_valid && s_ready;

    // flush items enter the buffers as empty cells
    assign cell_in = (s_item.func == ww_pkg::FUNC_FLUSH) ? ww_pkg::CELL_EMPTY
                                                         : s_item.cell_state;

    ww_pos_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos (
        .clk      (aclk),
        .rst_n    (aresetn),
        .cfg_cols (cfg_cols_reg),
        .cfg_rows (cfg_rows_reg),
        .accept   (accept),
        .pos      (pos),
        .col_addr (col_addr)
    );

    // Consecutive items never share a column (width is at least two), and a
    // write-back lands no later than the edge the next item is read, so no forwarding.
    assign ram_wr_en   = clr_busy_reg || win_wr_en;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : win_wr_addr;
    assign ram_wr_data = clr_busy_reg ? '0 : win_wr_data;

    ww_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (col_addr),
        .rd_data (ram_rd_data)
    );

    ww_window #(
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .clk      (aclk),
        .rst_n    (aresetn),
        .accept   (accept),
        .pos      (pos),
        .col_addr (col_addr),
        .cell_in  (cell_in),
        .rd_data  (ram_rd_data),
        .m_ready  (m_ready),
        .take_ok  (take_ok),
        .wr_en    (win_wr_en),
        .wr_addr  (win_wr_addr),
        .wr_data  (win_wr_data),
        .m_valid  (m_valid),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

FILE: src/ww_checker.sv
// ============================================================================
// ww_checker: port-level checks for the Wireworld generation stream
// Watches handshakes and frame boundaries; bound to the top level.
// ============================================================================
`default_nettype none

module ww_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire ww_pkg::in_item_t               s_item,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire ww_pkg::out_item_t              m_item
);

    // set once a frame has ended (or after reset): next result is the top-left cell
    logic frame_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_start_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            frame_start_reg <= m_item.frame_end;
        end
    end

    // a waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // the line-buffer clear keeps input closed right after reset
    a_clear_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open during line-buffer clear");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // each generation starts at row 0, column 0
    a_frame_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_start_reg && m_valid |-> (m_item.cell_row == '0) && (m_item.cell_col == '0))
        else $error("generation does not start at the origin");

endmodule

bind wireworld_generation_stream_top ww_checker u_ww_checker (.*);

`default_nettype wire
